>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define CHK_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define CHK_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

>>> rtl/swdw_pkg.sv
// Shared types, constants and helper functions of the swirl coordinate warp.
package swdw_pkg;

   localparam int IMAGE_SIZE    = 256;
   localparam int CORDIC_STAGES = 16;
   localparam int MAX_COORD     = ((IMAGE_SIZE - 1) > 255) ? 255 : (IMAGE_SIZE - 1);

   localparam int ANG_PI        = 25736;
   localparam int ANG_TWO_PI    = 51472;
   localparam int ANG_HALF_PI   = 12868;
   localparam int CORDIC_GAIN   = 9949;
   localparam int ROOT_BITS     = 16;
   localparam int WRAP_STEPS    = 7;
   localparam int WRAP_W        = 23;
   localparam int ADDR_W        = 4;

   // register byte addresses, word index in paddr[3:2]
   typedef enum logic [1:0] {
      REG_RADIUS = 2'd0,
      REG_RATE   = 2'd1,
      REG_TWIST  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic              off;
      logic signed [8:0] dr;
      logic signed [8:0] dc;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic [18:0] rem;
      logic [15:0] root;
      logic [15:0] bits;
   } sqrt_type;

   typedef struct packed {
      item_type           item;
      logic               neg;
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [17:0] z;
   } cordic_type;

   // arctan(2^-i) in Q3.13, rounded
   function automatic logic signed [17:0] atan_q13(input logic [4:0] idx);
      logic signed [17:0] a;
      case (idx)
         5'd0:    a = 18'sd6434;
         5'd1:    a = 18'sd3798;
         5'd2:    a = 18'sd2007;
         5'd3:    a = 18'sd1019;
         5'd4:    a = 18'sd511;
         5'd5:    a = 18'sd256;
         5'd6:    a = 18'sd128;
         5'd7:    a = 18'sd64;
         5'd8:    a = 18'sd32;
         5'd9:    a = 18'sd16;
         5'd10:   a = 18'sd8;
         5'd11:   a = 18'sd4;
         5'd12:   a = 18'sd2;
         5'd13:   a = 18'sd1;
         default: a = 18'sd0;
      endcase
      return a;
   endfunction

   // multiple of two pi taken off at wrap step k
   function automatic logic [WRAP_W-1:0] wrap_const(input int k);
      return WRAP_W'(ANG_TWO_PI << (WRAP_STEPS - 1 - k));
   endfunction

   // truncate a Q14 coordinate and clamp it to the image
   function automatic logic [7:0] to_coord(input logic signed [27:0] t);
      logic [13:0] v;
      v = t[27:14];
      if (t[27]) begin
         return 8'd0;
      end else if (v > 14'(MAX_COORD)) begin
         return 8'(MAX_COORD);
      end
      return v[7:0];
   endfunction

endpackage

>>> rtl/swdw_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module swdw_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  swdw_pkg::sqrt_type in_data,
   output logic              out_valid,
   output swdw_pkg::sqrt_type out_data
);

   logic               valid_ff;
   swdw_pkg::sqrt_type data_ff, data_in;
   logic [18:0]        rem2;
   logic [18:0]        trial;
   logic               ge;

   // bring in the next two radicand bits and try a one digit
   always_comb begin
      rem2  = {in_data.rem[16:0], in_data.bits[15:14]};
      trial = {1'b0, in_data.root, 2'b01};
      ge    = rem2 >= trial;
      data_in      = in_data;
      data_in.bits = {in_data.bits[13:0], 2'b00};
      data_in.rem  = ge ? (rem2 - trial) : rem2;
      data_in.root = {in_data.root[14:0], ge};
   end

   // advance the cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/swdw_cordic_cell.sv
// One rotation cell of the pipelined CORDIC.
module swdw_cordic_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [4:0]          idx,
   input  logic                in_valid,
   input  swdw_pkg::cordic_type in_data,
   output logic                out_valid,
   output swdw_pkg::cordic_type out_data
);

   logic                 valid_ff;
   swdw_pkg::cordic_type data_ff, data_in;
   logic signed [17:0]   xs, ys, ang;

   // rotate toward zero residual angle
   always_comb begin
      xs  = in_data.x >>> idx;
      ys  = in_data.y >>> idx;
      ang = swdw_pkg::atan_q13(idx);
      data_in = in_data;
      if (!in_data.z[17]) begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ang;
      end else begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ang;
      end
   end

   // advance the cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/swirl_disk_coordinate_warp.sv
// Swirl disk coordinate warp: top level with register port and pipeline.
//
// Usage: present a destination pixel on req_dest_row/req_dest_col with
// req_valid; the beat is taken when req_stall is low. Each beat yields one
// rsp beat: rsp_off_disk flags pixels at or beyond the disk radius
// (source fields zero), else rsp_src_row/rsp_src_col give the
// clamped source pixel to sample.
// Pipeline from accepted req beat to rsp_valid: the offsets, the squared
// distance, 16 square root cells, one multiply, one angle sum, 7 wrap
// steps, one quadrant fold, 16 CORDIC cells, one multiply and the output
// register. Throughput is one beat per cycle while no result is held.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall rises; it falls again as soon as the result moves on.
// Registers sit at byte addresses 0 (disk_radius), 4 (swirl_rate) and
// 8 (twist_offset) on the csr port; write them only while idle.
// Reset empties the pipeline and loads radius 128, rate 936, twist 16384.
module swirl_disk_coordinate_warp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_dest_row,
   input  logic [7:0]  req_dest_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_off_disk,
   output logic [7:0]  rsp_src_row,
   output logic [7:0]  rsp_src_col,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [swdw_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NS = swdw_pkg::CORDIC_STAGES;
   localparam int NR = swdw_pkg::ROOT_BITS;
   localparam int NW = swdw_pkg::WRAP_STEPS;
   localparam int WW = swdw_pkg::WRAP_W;

   logic [7:0]  radius_ff;
   logic [15:0] rate_ff;
   logic [15:0] twist_ff;
   logic        en;
   swdw_pkg::reg_index_type reg_sel;

   // register port
   assign csr_pready = 1'b1;
   assign reg_sel    = swdw_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 8'd128;
         rate_ff   <= 16'd936;
         twist_ff  <= 16'd16384;
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[1:0] == 2'b00)) begin
         case (reg_sel)
            swdw_pkg::REG_RADIUS: radius_ff <= csr_pwdata[7:0];
            swdw_pkg::REG_RATE:   rate_ff   <= csr_pwdata[15:0];
            swdw_pkg::REG_TWIST:  twist_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[1:0] == 2'b00) begin
         case (reg_sel)
            swdw_pkg::REG_RADIUS: csr_prdata = {24'd0, radius_ff};
            swdw_pkg::REG_RATE:   csr_prdata = {16'd0, rate_ff};
            swdw_pkg::REG_TWIST:  csr_prdata = {16'd0, twist_ff};
            default:              csr_prdata = 32'd0;
         endcase
      end
   end

   // freeze everything while a finished result is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // offsets from the disk centre
   logic               s0_valid_ff;
   logic signed [8:0]  s0_dr_ff, s0_dc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
      if (en) begin
         s0_dr_ff <= $signed({1'b0, req_dest_row}) - $signed({1'b0, radius_ff});
         s0_dc_ff <= $signed({1'b0, req_dest_col}) - $signed({1'b0, radius_ff});
      end
   end

   // squared distance and disk test
   logic signed [17:0] sq_r, sq_c;
   logic [17:0]        d2;
   logic [15:0]        rr;
   swdw_pkg::sqrt_type sq_in;
   swdw_pkg::sqrt_type sq_d [0:NR];
   logic               sq_v [0:NR];

   always_comb begin
      sq_r = s0_dr_ff * s0_dr_ff;
      sq_c = s0_dc_ff * s0_dc_ff;
      d2   = 18'(sq_r) + 18'(sq_c);
      rr   = radius_ff * radius_ff;
      sq_in.item.off = d2 >= {2'b00, rr};
      sq_in.item.dr  = s0_dr_ff;
      sq_in.item.dc  = s0_dc_ff;
      sq_in.rem      = '0;
      sq_in.root     = '0;
      sq_in.bits     = d2[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v[0] <= 1'b0;
      end else if (en) begin
         sq_v[0] <= s0_valid_ff;
      end
      if (en) begin
         sq_d[0] <= sq_in;
      end
   end

   // square root, one result bit per cell
   for (genvar i = 0; i < NR; i++) begin : g_sqrt
      swdw_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_v[i]),
         .in_data   (sq_d[i]),
         .out_valid (sq_v[i+1]),
         .out_data  (sq_d[i+1])
      );
   end

   // angle drop = distance * rate
   logic                  m_valid_ff;
   swdw_pkg::item_type    m_item_ff;
   logic [20:0]           m_drop_ff;
   logic [31:0]           prod;

   assign prod = sq_d[NR].root * rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= sq_v[NR];
      end
      if (en) begin
         m_item_ff <= sq_d[NR].item;
         m_drop_ff <= prod[31:11];
      end
   end

   // biased angle, kept positive for the wrap
   logic               w_valid_ff [0:NW];
   swdw_pkg::item_type w_item_ff  [0:NW];
   logic [WW-1:0]      w_u_ff     [0:NW];
   logic signed [23:0] u_sum;

   assign u_sum = 24'(signed'(twist_ff)) - $signed({3'b000, m_drop_ff})
                  + 24'(swdw_pkg::ANG_PI) + 24'(swdw_pkg::ANG_TWO_PI * 64);

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff[0] <= 1'b0;
      end else if (en) begin
         w_valid_ff[0] <= m_valid_ff;
      end
      if (en) begin
         w_item_ff[0] <= m_item_ff;
         w_u_ff[0]    <= u_sum[WW-1:0];
      end
   end

   // take off multiples of two pi, largest first
   for (genvar k = 0; k < NW; k++) begin : g_wrap
      always_ff @(posedge clock) begin
         if (reset) begin
            w_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            w_valid_ff[k+1] <= w_valid_ff[k];
         end
         if (en) begin
            w_item_ff[k+1] <= w_item_ff[k];
            w_u_ff[k+1]    <= (w_u_ff[k] >= swdw_pkg::wrap_const(k))
                              ? (w_u_ff[k] - swdw_pkg::wrap_const(k)) : w_u_ff[k];
         end
      end
   end

   // fold into the right half plane
   logic signed [17:0]   phi;
   swdw_pkg::cordic_type cd_in;
   swdw_pkg::cordic_type cd_d [0:NS];
   logic                 cd_v [0:NS];

   always_comb begin
      phi = $signed({1'b0, w_u_ff[NW][16:0]}) - 18'sd25736;
      cd_in.item = w_item_ff[NW];
      cd_in.x    = 18'(swdw_pkg::CORDIC_GAIN);
      cd_in.y    = '0;
      cd_in.neg  = 1'b0;
      cd_in.z    = phi;
      if (phi > 18'sd12868) begin
         cd_in.z   = phi - 18'sd25736;
         cd_in.neg = 1'b1;
      end else if (phi < -18'sd12868) begin
         cd_in.z   = phi + 18'sd25736;
         cd_in.neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_v[0] <= 1'b0;
      end else if (en) begin
         cd_v[0] <= w_valid_ff[NW];
      end
      if (en) begin
         cd_d[0] <= cd_in;
      end
   end

   // CORDIC rotation chain
   for (genvar i = 0; i < NS; i++) begin : g_cordic
      swdw_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .idx       (5'(i)),
         .in_valid  (cd_v[i]),
         .in_data   (cd_d[i]),
         .out_valid (cd_v[i+1]),
         .out_data  (cd_d[i+1])
      );
   end

   // rotate the offset vector
   logic                p_valid_ff;
   logic                p_off_ff;
   logic signed [26:0]  p_rc_ff, p_cs_ff, p_rs_ff, p_cc_ff;
   logic signed [17:0]  cos_v, sin_v;

   assign cos_v = cd_d[NS].neg ? -cd_d[NS].x : cd_d[NS].x;
   assign sin_v = cd_d[NS].neg ? -cd_d[NS].y : cd_d[NS].y;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= cd_v[NS];
      end
      if (en) begin
         p_off_ff <= cd_d[NS].item.off;
         p_rc_ff  <= cd_d[NS].item.dr * cos_v;
         p_cs_ff  <= cd_d[NS].item.dc * sin_v;
         p_rs_ff  <= cd_d[NS].item.dr * sin_v;
         p_cc_ff  <= cd_d[NS].item.dc * cos_v;
      end
   end

   // recenter, truncate and clamp into the output register
   logic signed [27:0] rbase, row_t, col_t;
   logic               out_valid_ff;
   logic               out_off_ff;
   logic [7:0]         out_row_ff, out_col_ff;

   assign rbase = $signed({6'd0, radius_ff, 14'd0});
   assign row_t = 28'(p_rc_ff) - 28'(p_cs_ff) + rbase;
   assign col_t = 28'(p_rs_ff) + 28'(p_cc_ff) + rbase;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= p_valid_ff;
      end
      if (en) begin
         out_off_ff <= p_off_ff;
         out_row_ff <= p_off_ff ? 8'd0 : swdw_pkg::to_coord(row_t);
         out_col_ff <= p_off_ff ? 8'd0 : swdw_pkg::to_coord(col_t);
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_off_disk = out_off_ff;
   assign rsp_src_row  = out_row_ff;
   assign rsp_src_col  = out_col_ff;

endmodule

>>> rtl/swdw_checker.sv
// Port-level checks for the swirl coordinate warp, bound to the top level.
`include "assert_macros.svh"

module swdw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_off_disk,
   input logic [7:0] rsp_src_row,
   input logic [7:0] rsp_src_col,
   input logic       csr_pready
);

   // an off-disk beat carries zero coordinates
   `CHK_ALWAYS(a_off_zero, !(rsp_valid && rsp_off_disk) || (rsp_src_row == 8'd0 && rsp_src_col == 8'd0))

   // input side only backs up behind a held result
   `CHK_ALWAYS(a_stall_cause, !req_stall || (rsp_valid && rsp_stall))

   // a held result stays offered
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // register port never waits
   `CHK_ALWAYS(a_pready, csr_pready)

endmodule

bind swirl_disk_coordinate_warp swdw_checker u_swdw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_off_disk (rsp_off_disk),
   .rsp_src_row  (rsp_src_row),
   .rsp_src_col  (rsp_src_col),
   .csr_pready   (csr_pready)
);

>>> tb/sv/tb_top.sv
// Testbench for the swirl disk coordinate warp: random pixels, CSR phases, scoreboard check.
`timescale 1ns / 100ps

module tb_top;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_dest_row;
   logic [7:0]  req_dest_col;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_off_disk;
   logic [7:0]  rsp_src_row;
   logic [7:0]  rsp_src_col;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [swdw_pkg::ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   typedef struct {
      logic [7:0] row;
      logic [7:0] col;
   } pixel_type;

   typedef struct {
      logic       off;
      logic [7:0] row;
      logic [7:0] col;
   } warp_type;

   localparam int LATENCY = 46;
   localparam int LIMIT_CYCLES = 400000;

   pixel_type pixel_queue[$];
   warp_type  warp_queue[$];

   // model copy of the registers
   logic [7:0]  m_radius;
   logic [15:0] m_rate;
   logic [15:0] m_twist;

   int  errors;
   int  cycles;
   bit  req_hold;
   bit  req_accepted;
   bit  burst_enable;
   int  rsp_hold_cycles;
   int  req_gap;
   int  rsp_gap;

   swirl_disk_coordinate_warp dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // arctan table in Q3.13
   function automatic int atan_entry(input int i);
      int tbl[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      return (i < 14) ? tbl[i] : 0;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [7:0] clamp_coord(input int t);
      int v;
      if (t < 0) return 8'd0;
      v = t >>> 14;
      if (v > swdw_pkg::MAX_COORD) v = swdw_pkg::MAX_COORD;
      return v[7:0];
   endfunction

   // compute the swirl source coordinate for one pixel
   function automatic warp_type warp_pixel(input pixel_type p);
      warp_type w;
      int r, dr, dc, d2, x, y, z, xs, ys, c, s, i;
      longint unsigned dist_q8, drop;
      longint phi, m;
      bit neg;
      r = int'(m_radius);
      dr = int'(p.row) - r;
      dc = int'(p.col) - r;
      d2 = dr * dr + dc * dc;
      if (d2 >= r * r) begin
         w.off = 1'b1;
         w.row = 8'd0;
         w.col = 8'd0;
         return w;
      end
      dist_q8 = int_sqrt(longint'(d2) << 16);
      drop = (dist_q8 * longint'(m_rate)) >> 11;
      phi = longint'($signed(m_twist)) - longint'(drop);
      m = (phi + swdw_pkg::ANG_PI) % swdw_pkg::ANG_TWO_PI;
      if (m < 0) m += swdw_pkg::ANG_TWO_PI;
      phi = m - swdw_pkg::ANG_PI;
      neg = 1'b0;
      if (phi > swdw_pkg::ANG_HALF_PI) begin
         phi -= swdw_pkg::ANG_PI;
         neg = 1'b1;
      end else if (phi < -swdw_pkg::ANG_HALF_PI) begin
         phi += swdw_pkg::ANG_PI;
         neg = 1'b1;
      end
      x = swdw_pkg::CORDIC_GAIN;
      y = 0;
      z = int'(phi);
      for (i = 0; i < swdw_pkg::CORDIC_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z -= atan_entry(i);
         end else begin
            x = x + ys;
            y = y - xs;
            z += atan_entry(i);
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
      w.off = 1'b0;
      w.row = clamp_coord(dr * c - dc * s + (r << 14));
      w.col = clamp_coord(dr * s + dc * c + (r << 14));
      return w;
   endfunction

   // drive request beats from the pending pixel queue
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (!req_hold && pixel_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_dest_row <= pixel_queue[0].row;
            req_dest_col <= pixel_queue[0].col;
            if (burst_enable && $urandom_range(0, 15) == 0) req_gap <= $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict on each accepted request beat and retire it from the queue
   always @(posedge clock) begin
      req_accepted = !reset && req_valid && !req_stall;
      if (req_accepted) begin
         warp_queue.push_back(warp_pixel('{row: req_dest_row, col: req_dest_col}));
         void'(pixel_queue.pop_front());
      end
   end

   // receiver stall: random bursts plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (burst_enable && $urandom_range(0, 15) == 0) rsp_gap <= $urandom_range(1, 10);
      end
   end

   // check each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      warp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (warp_queue.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            w = warp_queue.pop_front();
            if (rsp_off_disk !== w.off) begin
               $error("off_disk expected %0d actual %0d", w.off, rsp_off_disk);
               errors++;
            end
            if (rsp_src_row !== w.row) begin
               $error("src_row expected %0d actual %0d", w.row, rsp_src_row);
               errors++;
            end
            if (rsp_src_col !== w.col) begin
               $error("src_col expected %0d actual %0d", w.col, rsp_src_col);
               errors++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic csr_write(input swdw_pkg::reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= swdw_pkg::ADDR_W'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         swdw_pkg::REG_RADIUS: m_radius = value[7:0];
         swdw_pkg::REG_RATE:   m_rate = value[15:0];
         swdw_pkg::REG_TWIST:  m_twist = value[15:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pixel_queue.size() != 0 || warp_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic add_pixel(input logic [7:0] row, input logic [7:0] col);
      pixel_queue.push_back('{row: row, col: col});
   endtask

   // random pixels, mostly inside the disk
   task automatic add_random(input int count);
      int i, r;
      for (i = 0; i < count; i++) begin
         r = int'(m_radius);
         if ($urandom_range(0, 3) == 0 || r == 0)
            add_pixel(8'($urandom), 8'($urandom));
         else
            add_pixel(8'($urandom_range(0, 2 * r - 1)), 8'($urandom_range(0, 2 * r - 1)));
      end
   endtask

   task automatic phase(input logic [7:0] rad, input logic [15:0] rate,
                        input logic [15:0] twist, input int count);
      csr_write(swdw_pkg::REG_RADIUS, {24'd0, rad});
      csr_write(swdw_pkg::REG_RATE, {16'd0, rate});
      csr_write(swdw_pkg::REG_TWIST, {16'd0, twist});
      add_random(count);
      drain();
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      req_hold = 1'b0;
      burst_enable = 1'b1;
      rsp_hold_cycles = 0;
      req_gap = 0;
      rsp_gap = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_dest_row = 8'd0;
      req_dest_col = 8'd0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      m_radius = 8'd128;
      m_rate = 16'd936;
      m_twist = 16'd16384;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: corners, centre, disk edge at reset settings
      add_pixel(8'd0, 8'd0);
      add_pixel(8'd255, 8'd255);
      add_pixel(8'd0, 8'd255);
      add_pixel(8'd255, 8'd0);
      add_pixel(8'd128, 8'd128);
      add_pixel(8'd128, 8'd0);
      add_pixel(8'd128, 8'd1);
      add_pixel(8'd1, 8'd128);
      add_pixel(8'd127, 8'd129);
      add_pixel(8'd200, 8'd60);
      drain();
      // zero radius: everything off the disk
      csr_write(swdw_pkg::REG_RADIUS, 32'd0);
      add_pixel(8'd0, 8'd0);
      add_pixel(8'd255, 8'd128);
      drain();
      // radius at its maximum and twist out of range
      csr_write(swdw_pkg::REG_RADIUS, 32'd255);
      csr_write(swdw_pkg::REG_TWIST, 32'h8000);
      csr_write(swdw_pkg::REG_RATE, 32'hFFFF);
      add_pixel(8'd255, 8'd255);
      add_pixel(8'd0, 8'd255);
      add_pixel(8'd130, 8'd100);
      add_pixel(8'd254, 8'd254);
      drain();
      csr_write(swdw_pkg::REG_RADIUS, 32'd1);
      csr_write(swdw_pkg::REG_TWIST, 32'h7FFF);
      csr_write(swdw_pkg::REG_RATE, 32'd0);
      add_pixel(8'd1, 8'd1);
      add_pixel(8'd0, 8'd1);
      drain();

      // random phases over several settings
      phase(8'd128, 16'd936, 16'd16384, 250);
      phase(8'd128, 16'd0, 16'($signed(-25736)), 150);
      phase(8'd64, 16'd65535, 16'd25735, 150);
      phase(8'd1, 16'($urandom), 16'($urandom), 40);
      phase(8'd200, 16'($urandom), 16'($urandom), 150);
      phase(8'($urandom_range(2, 128)), 16'($urandom), 16'($urandom), 150);

      // long receiver hold-off while the sender keeps offering
      csr_write(swdw_pkg::REG_RADIUS, 32'd100);
      rsp_hold_cycles = 150;
      add_random(200);
      drain();

      // sender pause, then wait until every result has come
      req_hold = 1'b1;
      add_random(100);
      repeat (20) @(posedge clock);
      req_hold = 1'b0;
      while (warp_queue.size() != 0 || pixel_queue.size() != 0) @(posedge clock);
      phase(8'd255, 16'($urandom), 16'($urandom), 150);

      // last part without idling
      burst_enable = 1'b0;
      phase(8'd128, 16'($urandom), 16'($urandom), 300);

      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/swdw_pkg.sv
rtl/swdw_sqrt_cell.sv
rtl/swdw_cordic_cell.sv
rtl/swirl_disk_coordinate_warp.sv
rtl/swdw_checker.sv
tb/sv/tb_top.sv
